// File: hdl/scl_pkg.sv
// Shared constants, tables and types for the serial command line recognizer.
`default_nettype none
package scl_pkg;

  localparam int LINE_CAPACITY_DEF = 20;
  localparam int NUM_WORDS = 8;
  localparam int WORD_MAX = 6;
  localparam int REPLY_LEN = 19;

  localparam logic [3:0] CODE_NONE = 4'd8;

  localparam logic [7:0] CHAR_NUL = 8'h00;
  localparam logic [7:0] CHAR_BS  = 8'h08;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;
  localparam logic [7:0] CHAR_DEL = 8'h7F;

  localparam logic [2:0] CMD_LEN [NUM_WORDS] = '{
    3'd3, 3'd4, 3'd3, 3'd4, 3'd6, 3'd6, 3'd6, 3'd4
  };

  localparam logic [7:0] CMD_CHARS [NUM_WORDS][WORD_MAX] = '{
    '{"R", "O", "N", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"R", "O", "F", "F", CHAR_NUL, CHAR_NUL},
    '{"G", "O", "N", CHAR_NUL, CHAR_NUL, CHAR_NUL},
    '{"G", "O", "F", "F", CHAR_NUL, CHAR_NUL},
    '{"R", "F", "L", "A", "S", "H"},
    '{"G", "F", "L", "A", "S", "H"},
    '{"A", "L", "L", "O", "F", "F"},
    '{"H", "E", "L", "P", CHAR_NUL, CHAR_NUL}
  };

  localparam logic [7:0] REPLY_BYTES [REPLY_LEN] = '{
    CHAR_CR, CHAR_LF,
    "I", "n", "v", "a", "l", "i", "d", CHAR_SP,
    "C", "o", "m", "m", "a", "n", "d",
    CHAR_CR, CHAR_LF
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_DEL,
    S_CMP_WORD,
    S_CMP_RD,
    S_CMP_CHK,
    S_REPLY
  } state_t;

endpackage
`default_nettype wire

// File: hdl/scl_in_if.sv
// Receive channel carrying one input byte per beat.
`default_nettype none
interface scl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// File: hdl/scl_out_if.sv
// Transmit channel carrying one echo or message byte with its event flags per beat.
`default_nettype none
interface scl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       event_valid;
  logic [3:0] event_code;
  logic       last;

  modport source (output valid, output tx_byte, output event_valid, output event_code,
                  output last, input ready);
  modport sink (input valid, input tx_byte, input event_valid, input event_code,
                input last, output ready);
endinterface
`default_nettype wire

// File: hdl/serial_command_line_recognizer.sv
// Top level of the serial command line recognizer: line buffer, matcher and reply sequencer.
//
//   channel  dir  beat payload                                  accepted when
//   rx       in   rx_byte                                       rx.valid && rx.ready
//   tx       out  tx_byte, event_valid, event_code, last        tx.valid && tx.ready
//
// A byte is taken only while the sequencer is idle; a stored byte is echoed and a delete
// sends backspace, space, backspace. A line end compares the line length with each
// command word, reads and checks each character of a length match from the line RAM,
// then sends a reply of 2 or 19 beats. Reset clears the length and the sequencer; the line RAM is
// not cleared. A stalled tx holds the sequencer at its current beat.
`default_nettype none
module serial_command_line_recognizer #(
  parameter int LINE_CAPACITY = scl_pkg::LINE_CAPACITY_DEF
) (
  input wire logic clk,
  input wire logic rst,
  scl_in_if.sink   rx,
  scl_out_if.source tx
);
  import scl_pkg::*;

  localparam int ADDR_W = $clog2(LINE_CAPACITY);
  localparam int LEN_W  = $clog2(LINE_CAPACITY + 1);
  localparam logic [LEN_W-1:0] CAP = LEN_W'(LINE_CAPACITY);

  state_t           state, state_next;
  logic [LEN_W-1:0] line_length, line_length_next;
  logic [2:0]       word_idx, word_idx_next;
  logic [2:0]       char_idx, char_idx_next;
  logic [4:0]       seq_idx, seq_idx_next;
  logic [3:0]       code, code_next;
  logic [7:0]       held, held_next;

  logic             out_valid, out_valid_next;
  logic [7:0]       out_byte, out_byte_next;
  logic             out_ev, out_ev_next;
  logic [3:0]       out_code, out_code_next;
  logic             out_last, out_last_next;

  logic             accept;
  logic             slot_free;
  logic             ram_we;
  logic [7:0]       ram_rdata;

  assign rx.ready      = (state == S_IDLE);
  assign accept        = rx.valid && rx.ready;
  assign slot_free     = !out_valid || tx.ready;
  assign tx.valid      = out_valid;
  assign tx.tx_byte    = out_byte;
  assign tx.event_valid = out_ev;
  assign tx.event_code = out_code;
  assign tx.last       = out_last;

  assign ram_we = accept && (rx.rx_byte != CHAR_NUL) && (rx.rx_byte != CHAR_CR) &&
                  (rx.rx_byte != CHAR_LF) && (rx.rx_byte != CHAR_DEL) &&
                  (line_length < CAP);

  scl_ram #(
    .WIDTH (8),
    .DEPTH (LINE_CAPACITY)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_length[ADDR_W-1:0]),
    .wdata (rx.rx_byte),
    .raddr (ADDR_W'(char_idx)),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      line_length <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      line_length <= line_length_next;
      out_valid   <= out_valid_next;
    end
    word_idx <= word_idx_next;
    char_idx <= char_idx_next;
    seq_idx  <= seq_idx_next;
    code     <= code_next;
    held     <= held_next;
    out_byte <= out_byte_next;
    out_ev   <= out_ev_next;
    out_code <= out_code_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next       = state;
    line_length_next = line_length;
    word_idx_next    = word_idx;
    char_idx_next    = char_idx;
    seq_idx_next     = seq_idx;
    code_next        = code;
    held_next        = held;
    out_valid_next   = out_valid && !tx.ready;
    out_byte_next    = out_byte;
    out_ev_next      = out_ev;
    out_code_next    = out_code;
    out_last_next    = out_last;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (rx.rx_byte == CHAR_CR || rx.rx_byte == CHAR_LF) begin
            word_idx_next = '0;
            state_next    = S_CMP_WORD;
          end else if (rx.rx_byte == CHAR_DEL) begin
            if (line_length != '0) begin
              line_length_next = line_length - LEN_W'(1);
              seq_idx_next     = '0;
              state_next       = S_DEL;
            end
          end else if (ram_we) begin
            line_length_next = line_length + LEN_W'(1);
            held_next        = rx.rx_byte;
            state_next       = S_ECHO;
          end
        end
      end
      S_ECHO: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = held;
          out_ev_next    = 1'b0;
          out_code_next  = CODE_NONE;
          out_last_next  = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DEL: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = (seq_idx == 5'd1) ? CHAR_SP : CHAR_BS;
          out_ev_next    = 1'b0;
          out_code_next  = CODE_NONE;
          out_last_next  = (seq_idx == 5'd2);
          seq_idx_next   = seq_idx + 5'd1;
          if (seq_idx == 5'd2) begin
            state_next = S_IDLE;
          end
        end
      end
      S_CMP_WORD: begin
        if (line_length == LEN_W'(CMD_LEN[word_idx])) begin
          char_idx_next = '0;
          state_next    = S_CMP_RD;
        end else if (word_idx == 3'(NUM_WORDS - 1)) begin
          code_next    = CODE_NONE;
          seq_idx_next = '0;
          state_next   = S_REPLY;
        end else begin
          word_idx_next = word_idx + 3'd1;
        end
      end
      S_CMP_RD: begin
        state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (ram_rdata != CMD_CHARS[word_idx][char_idx]) begin
          if (word_idx == 3'(NUM_WORDS - 1)) begin
            code_next    = CODE_NONE;
            seq_idx_next = '0;
            state_next   = S_REPLY;
          end else begin
            word_idx_next = word_idx + 3'd1;
            state_next    = S_CMP_WORD;
          end
        end else if (char_idx == CMD_LEN[word_idx] - 3'd1) begin
          code_next    = {1'b0, word_idx};
          seq_idx_next = '0;
          state_next   = S_REPLY;
        end else begin
          char_idx_next = char_idx + 3'd1;
          state_next    = S_CMP_RD;
        end
      end
      S_REPLY: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          out_byte_next  = REPLY_BYTES[seq_idx];
          seq_idx_next   = seq_idx + 5'd1;
          if ((code != CODE_NONE && seq_idx == 5'd1) ||
              seq_idx == 5'(REPLY_LEN - 1)) begin
            out_ev_next      = 1'b1;
            out_code_next    = code;
            out_last_next    = 1'b1;
            line_length_next = '0;
            state_next       = S_IDLE;
          end else begin
            out_ev_next   = 1'b0;
            out_code_next = CODE_NONE;
            out_last_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= CAP)
    else $error("line length beyond capacity");

  a_event_is_last: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.event_valid |-> tx.last)
    else $error("event beat is not the last beat of its byte");

  a_code_needs_event: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.event_code != CODE_NONE |-> tx.event_valid)
    else $error("command code shown without event flag");

  a_line_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && $past(state) == S_REPLY |-> line_length == '0)
    else $error("line not cleared after line end");

endmodule
`default_nettype wire

// File: hdl/scl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module scl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the serial command line recognizer.
`timescale 1ns / 1ps
module testbench;

  localparam int LINE_CAP = scl_pkg::LINE_CAPACITY_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 120;

  typedef enum logic [3:0] {
    CMD_RON, CMD_ROFF, CMD_GON, CMD_GOFF, CMD_RFLASH, CMD_GFLASH, CMD_ALLOFF, CMD_HELP,
    CMD_NONE
  } cmd_code_e;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       event_valid;
    logic [3:0] event_code;
    logic       last;
  } tx_beat_t;

  localparam logic [7:0] OPENING_BYTES [24] = '{
    scl_pkg::CHAR_NUL, scl_pkg::CHAR_DEL, scl_pkg::CHAR_CR,
    "R", "O", "N", scl_pkg::CHAR_LF,
    "H", "E", "L", "P", "x", scl_pkg::CHAR_DEL, scl_pkg::CHAR_CR,
    "r", "o", "n", scl_pkg::CHAR_CR,
    8'hFF, 8'h80, scl_pkg::CHAR_DEL, scl_pkg::CHAR_DEL, scl_pkg::CHAR_DEL, scl_pkg::CHAR_CR
  };

  string cmd_words [8] = '{"RON", "ROFF", "GON", "GOFF", "RFLASH", "GFLASH", "ALLOFF", "HELP"};
  string bad_text = "Invalid Command";
  int send_idle_table [4] = '{0, 54, 0, 35};
  int stall_table [4] = '{0, 0, 54, 35};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_off = 1'b0;
  logic pressure_on = 1'b0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int error_count = 0;

  logic [7:0] pending_rx [$];
  tx_beat_t expected_tx [$];
  logic [7:0] line_chars [LINE_CAP];
  int line_len = 0;

  scl_in_if rx_ch ();
  scl_out_if tx_ch ();

  serial_command_line_recognizer u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(string what);
    if (error_count < 40) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
    error_count++;
  endtask

  function automatic void push_beat(logic [7:0] b, logic ev, cmd_code_e code, logic fin);
    tx_beat_t beat;
    beat.tx_byte = b;
    beat.event_valid = ev;
    beat.event_code = code;
    beat.last = fin;
    expected_tx.push_back(beat);
  endfunction

  function automatic void recognize_byte(logic [7:0] b);
    cmd_code_e code;
    bit hit;
    if (b == scl_pkg::CHAR_NUL) begin
      return;
    end
    if (b == scl_pkg::CHAR_CR || b == scl_pkg::CHAR_LF) begin
      code = CMD_NONE;
      for (int w = 0; w < 8; w++) begin
        if (code == CMD_NONE && cmd_words[w].len() == line_len) begin
          hit = 1'b1;
          for (int i = 0; i < line_len; i++) begin
            if (line_chars[i] != cmd_words[w][i]) hit = 1'b0;
          end
          if (hit) code = cmd_code_e'(w);
        end
      end
      push_beat(scl_pkg::CHAR_CR, 1'b0, CMD_NONE, 1'b0);
      if (code != CMD_NONE) begin
        push_beat(scl_pkg::CHAR_LF, 1'b1, code, 1'b1);
      end else begin
        push_beat(scl_pkg::CHAR_LF, 1'b0, CMD_NONE, 1'b0);
        for (int i = 0; i < bad_text.len(); i++) begin
          push_beat(bad_text[i], 1'b0, CMD_NONE, 1'b0);
        end
        push_beat(scl_pkg::CHAR_CR, 1'b0, CMD_NONE, 1'b0);
        push_beat(scl_pkg::CHAR_LF, 1'b1, CMD_NONE, 1'b1);
      end
      line_len = 0;
    end else if (b == scl_pkg::CHAR_DEL) begin
      if (line_len > 0) begin
        line_len--;
        push_beat(scl_pkg::CHAR_BS, 1'b0, CMD_NONE, 1'b0);
        push_beat(scl_pkg::CHAR_SP, 1'b0, CMD_NONE, 1'b0);
        push_beat(scl_pkg::CHAR_BS, 1'b0, CMD_NONE, 1'b1);
      end
    end else if (line_len < LINE_CAP) begin
      line_chars[line_len] = b;
      line_len++;
      push_beat(b, 1'b0, CMD_NONE, 1'b1);
    end
  endfunction

  // Well-formed command lines half the time, plus near misses, junk lines and lone noise bytes.
  task automatic queue_line();
    int kind;
    int pos;
    string word;
    logic [7:0] b;
    kind = $urandom_range(99);
    word = cmd_words[$urandom_range(7)];
    if (kind < 50) begin
      pos = ($urandom_range(3) == 0) ? $urandom_range(word.len() - 1) : -1;
      for (int i = 0; i < word.len(); i++) begin
        if (i == pos) begin
          pending_rx.push_back(8'($urandom_range(33, 126)));
          if ($urandom_range(1)) pending_rx.push_back(scl_pkg::CHAR_NUL);
          pending_rx.push_back(scl_pkg::CHAR_DEL);
        end
        pending_rx.push_back(word[i]);
      end
    end else if (kind < 65) begin
      pos = $urandom_range(word.len() - 1);
      for (int i = 0; i < word.len(); i++) begin
        b = word[i];
        pending_rx.push_back((i == pos) ? (b ^ 8'h20) : b);
      end
      if ($urandom_range(1)) pending_rx.push_back(8'($urandom_range(65, 90)));
    end else if (kind < 85) begin
      pos = $urandom_range(26);
      for (int i = 0; i < pos; i++) begin
        b = 8'($urandom_range(1, 255));
        if (b == scl_pkg::CHAR_CR || b == scl_pkg::CHAR_LF) b = scl_pkg::CHAR_DEL;
        pending_rx.push_back(b);
      end
    end else begin
      pending_rx.push_back(8'($urandom_range(0, 255)));
      return;
    end
    pending_rx.push_back($urandom_range(1) ? scl_pkg::CHAR_CR : scl_pkg::CHAR_LF);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid <= 1'b0;
      rx_ch.rx_byte <= '0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        recognize_byte(rx_ch.rx_byte);
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if (pending_rx.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_ch.valid <= 1'b1;
          rx_ch.rx_byte <= pending_rx.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    tx_beat_t want;
    if (rst) begin
      tx_ch.ready <= 1'b0;
    end else begin
      if (tx_ch.valid && tx_ch.ready) begin
        if (expected_tx.size() == 0) begin
          flag_mismatch($sformatf("unexpected beat, tx_byte %02h", tx_ch.tx_byte));
        end else begin
          want = expected_tx.pop_front();
          if (tx_ch.tx_byte !== want.tx_byte) begin
            flag_mismatch($sformatf("tx_byte %02h, expected %02h",
                                    tx_ch.tx_byte, want.tx_byte));
          end
          if (tx_ch.event_valid !== want.event_valid) begin
            flag_mismatch($sformatf("event_valid %b, expected %b",
                                    tx_ch.event_valid, want.event_valid));
          end
          if (tx_ch.event_code !== want.event_code) begin
            flag_mismatch($sformatf("event_code %0d, expected %0d",
                                    tx_ch.event_code, want.event_code));
          end
          if (tx_ch.last !== want.last) begin
            flag_mismatch($sformatf("last %b, expected %b", tx_ch.last, want.last));
          end
        end
      end
      tx_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // The transmit side stops taking beats for a long stretch so the recognizer backs up.
  initial begin
    wait (pressure_on);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    tx_ch.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      send_idle_pct = send_idle_table[p];
      stall_pct = stall_table[p];
      if (p == 0) begin
        foreach (OPENING_BYTES[i]) pending_rx.push_back(OPENING_BYTES[i]);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n = n) begin
        n -= pending_rx.size();
        queue_line();
        n += pending_rx.size();
      end
      if (p == 0) pressure_on = 1'b1;
      do @(negedge clk); while (pending_rx.size() > 0 || rx_ch.valid || expected_tx.size() > 0);
    end
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_tx.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
